### rtl/core/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg: shared types and constants of the SQL token scanner
// Token kinds, error causes, character codes and the result record layout.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW = $clog2(OQ_DEPTH);

  typedef enum logic [4:0] {
    K_LPAREN = 5'd0,
    K_RPAREN = 5'd1,
    K_COMMA  = 5'd2,
    K_DOT    = 5'd3,
    K_SEMI   = 5'd4,
    K_SUB    = 5'd5,
    K_ADD    = 5'd6,
    K_MUL    = 5'd7,
    K_MOD    = 5'd8,
    K_DIV    = 5'd9,
    K_EQ     = 5'd10,
    K_NE     = 5'd11,
    K_LE     = 5'd12,
    K_LT     = 5'd13,
    K_GE     = 5'd14,
    K_GT     = 5'd15,
    K_STRING = 5'd16,
    K_IDENT  = 5'd17,
    K_INT    = 5'd18,
    K_DOUBLE = 5'd19,
    K_ERROR  = 5'd20
  } kind_t;

  typedef enum logic [1:0] {
    E_NONE       = 2'd0,
    E_UNEXPECTED = 2'd1,
    E_UNTERM     = 2'd2,
    E_RANGE      = 2'd3
  } cause_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  localparam logic [63:0] MAG_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_POS   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LIM_NEG   = 64'h0000_0000_8000_0000;
  localparam logic [15:0] LINE_MAX  = 16'hFFFF;
  localparam logic [7:0]  FRAC_MAX  = 8'hFF;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] start_offset;
    logic [15:0] lexeme_length;
    logic [15:0] line_number;
    logic [63:0] number_value;
    logic [7:0]  fraction_digits;
    cause_t      error_cause;
  } res_t;

  typedef struct packed {
    res_t res;
    logic last;
  } q_t;

  function automatic res_t mk_res(kind_t k, logic [15:0] s, logic [15:0] l,
                                  logic [15:0] ln, logic [63:0] v, logic [7:0] f,
                                  cause_t e);
    res_t r;
    r.kind = k;
    r.start_offset = s;
    r.lexeme_length = l;
    r.line_number = ln;
    r.number_value = v;
    r.fraction_digits = f;
    r.error_cause = e;
    return r;
  endfunction

endpackage

### rtl/core/sql_token_scanner.sv
// ----------------------------------------------------------------------------
// sql_token_scanner: streaming lexer for a small SQL dialect
// Groups source characters into tokens with offsets, length, line and value.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one item per cycle while in_tready is high:
//   in_tuser is the command (0 = source character, 1 = end of source) and
//   in_tdata the character. End of source flushes a pending token and
//   returns the scanner to its reset state. Each item yields zero, one or
//   two tokens on the output channel; out_tlast marks the last token
//   caused by an item. Tokens are written to the output queue as the item
//   is accepted, and the scan state is updated in the same cycle as the
//   accept; both tokens of an item are written at once and read out singly.
//   Tokens wait in a four-entry output queue. The input is held off while
//   fewer than two queue entries are free, so a stalled receiver backs the
//   source up and no token is lost.
//   Reset clears the scan state to idle at offset zero, line one, and
//   empties the queue.
//   After an unexpected character, an unterminated quote or an integer out
//   of range, the scanner emits an error token and ignores characters
//   until end of source.
// ----------------------------------------------------------------------------
module sql_token_scanner #(
  parameter int OFFSET_BITS = sts_pkg::OFFSET_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // ch
  input  logic         in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  // start_offset, lexeme_length, line_number, number_value, fraction_digits,
  // error_cause, zero fill
  output logic [127:0] out_tdata,
  output logic [4:0]   out_tuser,  // kind
  output logic         out_tlast
);

  typedef enum logic [3:0] {
    M_IDLE, M_LT, M_GT, M_MINUS, M_PLUS, M_COMMENT, M_QUOTE, M_INT, M_FRAC, M_HALT
  } mode_t;

  mode_t                  mode_r, mode_nxt;
  logic                   qsingle_r, qsingle_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] tstart_r, tstart_nxt;
  logic [15:0]            line_r, line_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic                   neg_r, neg_nxt;
  logic [7:0]             frac_r, frac_nxt;
  logic                   ovf_r, ovf_nxt;

  sts_pkg::q_t            mem_r [sts_pkg::OQ_DEPTH];
  logic [sts_pkg::OQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [sts_pkg::OQ_AW:0]   count_r;

  logic       accept, rd;
  logic       cmd;
  logic [7:0] c;
  logic       is_dig;

  logic        dig_cont, dig_neg;
  logic [63:0] dig_base;
  logic [67:0] dig_sum;
  logic [63:0] dig_acc;
  logic        dig_ovf;

  sts_pkg::res_t res_a, res_b;
  logic          va, vb, do_idle;
  logic [1:0]    n_res;
  sts_pkg::q_t   e0, e1;

  logic [63:0] sval;
  logic [OFFSET_BITS-1:0] span_raw, span_raw1;
  logic [15:0] span_off, span_off1, ts16, off16, line_inc;

  assign cmd = in_tuser;
  assign c = in_tdata;
  assign is_dig = (c >= sts_pkg::CH_0) && (c <= sts_pkg::CH_9);
  assign accept = in_tvalid && in_tready;
  assign rd = out_tvalid && out_tready;
  assign in_tready = count_r <= (sts_pkg::OQ_AW + 1)'(sts_pkg::OQ_DEPTH - 2);

  // Multiply-by-ten accumulate of one digit, saturating the magnitude.
  assign dig_cont = (mode_r == M_INT) || (mode_r == M_FRAC);
  assign dig_neg = dig_cont ? neg_r : (mode_r == M_MINUS);
  assign dig_base = dig_cont ? acc_r : 64'd0;
  assign dig_sum = {1'b0, dig_base, 3'b000} + {3'b000, dig_base, 1'b0} + {64'd0, c[3:0]};
  assign dig_acc = (dig_sum > {4'd0, sts_pkg::MAG_MAX}) ? sts_pkg::MAG_MAX : dig_sum[63:0];
  assign dig_ovf = (dig_cont && ovf_r) ||
                   (dig_acc > (dig_neg ? sts_pkg::LIM_NEG : sts_pkg::LIM_POS));

  assign sval = neg_r ? (64'd0 - acc_r) : acc_r;
  assign span_raw = off_r - tstart_r;
  assign span_raw1 = off_r + 1'b1 - tstart_r;
  assign span_off = 16'(span_raw);
  assign span_off1 = 16'(span_raw1);
  assign ts16 = 16'(tstart_r);
  assign off16 = 16'(off_r);
  assign line_inc = (line_r != sts_pkg::LINE_MAX) ? line_r + 16'd1 : line_r;

  always_comb begin
    mode_nxt = mode_r;
    qsingle_nxt = qsingle_r;
    off_nxt = off_r;
    tstart_nxt = tstart_r;
    line_nxt = line_r;
    acc_nxt = acc_r;
    neg_nxt = neg_r;
    frac_nxt = frac_r;
    ovf_nxt = ovf_r;
    res_a = '0;
    res_b = '0;
    va = 1'b0;
    vb = 1'b0;
    do_idle = 1'b0;

    if (cmd) begin
      unique case (mode_r)
        M_LT: begin
          va = 1'b1;
          res_a = sts_pkg::mk_res(sts_pkg::K_LT, ts16, 16'd1, line_r, '0, '0, sts_pkg::E_NONE);
        end
        M_GT: begin
          va = 1'b1;
          res_a = sts_pkg::mk_res(sts_pkg::K_GT, ts16, 16'd1, line_r, '0, '0, sts_pkg::E_NONE);
        end
        M_MINUS: begin
          va = 1'b1;
          res_a = sts_pkg::mk_res(sts_pkg::K_SUB, ts16, 16'd1, line_r, '0, '0, sts_pkg::E_NONE);
        end
        M_PLUS: begin
          va = 1'b1;
          res_a = sts_pkg::mk_res(sts_pkg::K_ADD, ts16, 16'd1, line_r, '0, '0, sts_pkg::E_NONE);
        end
        M_QUOTE: begin
          va = 1'b1;
          res_a = sts_pkg::mk_res(sts_pkg::K_ERROR, ts16, span_off, line_r, '0, '0,
                                  sts_pkg::E_UNTERM);
        end
        M_INT: begin
          va = 1'b1;
          if (ovf_r) begin
            res_a = sts_pkg::mk_res(sts_pkg::K_ERROR, ts16, span_off, line_r, '0, '0,
                                    sts_pkg::E_RANGE);
          end else begin
            res_a = sts_pkg::mk_res(sts_pkg::K_INT, ts16, span_off, line_r, sval, '0,
                                    sts_pkg::E_NONE);
          end
        end
        M_FRAC: begin
          va = 1'b1;
          res_a = sts_pkg::mk_res(sts_pkg::K_DOUBLE, ts16, span_off, line_r, sval, frac_r,
                                  sts_pkg::E_NONE);
        end
        default: begin
        end
      endcase
      mode_nxt = M_IDLE;
      qsingle_nxt = 1'b0;
      off_nxt = '0;
      tstart_nxt = '0;
      line_nxt = 16'd1;
      acc_nxt = '0;
      neg_nxt = 1'b0;
      frac_nxt = '0;
      ovf_nxt = 1'b0;
    end else begin
      off_nxt = off_r + 1'b1;
      unique case (mode_r)
        M_IDLE: do_idle = 1'b1;
        M_LT: begin
          va = 1'b1;
          mode_nxt = M_IDLE;
          if (c == sts_pkg::CH_GT) begin
            res_a = sts_pkg::mk_res(sts_pkg::K_NE, ts16, 16'd2, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end else if (c == sts_pkg::CH_EQ) begin
            res_a = sts_pkg::mk_res(sts_pkg::K_LE, ts16, 16'd2, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end else begin
            res_a = sts_pkg::mk_res(sts_pkg::K_LT, ts16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
            do_idle = 1'b1;
          end
        end
        M_GT: begin
          va = 1'b1;
          mode_nxt = M_IDLE;
          if (c == sts_pkg::CH_EQ) begin
            res_a = sts_pkg::mk_res(sts_pkg::K_GE, ts16, 16'd2, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end else begin
            res_a = sts_pkg::mk_res(sts_pkg::K_GT, ts16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
            do_idle = 1'b1;
          end
        end
        M_MINUS: begin
          if (c == sts_pkg::CH_MINUS) begin
            mode_nxt = M_COMMENT;
          end else if (is_dig) begin
            acc_nxt = dig_acc;
            neg_nxt = 1'b1;
            frac_nxt = '0;
            ovf_nxt = dig_ovf;
            mode_nxt = M_INT;
          end else begin
            va = 1'b1;
            res_a = sts_pkg::mk_res(sts_pkg::K_SUB, ts16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_PLUS: begin
          if (is_dig) begin
            acc_nxt = dig_acc;
            neg_nxt = 1'b0;
            frac_nxt = '0;
            ovf_nxt = dig_ovf;
            mode_nxt = M_INT;
          end else begin
            va = 1'b1;
            res_a = sts_pkg::mk_res(sts_pkg::K_ADD, ts16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == sts_pkg::CH_LF) begin
            line_nxt = line_inc;
            mode_nxt = M_IDLE;
          end
        end
        M_QUOTE: begin
          if (c == sts_pkg::CH_LF) begin
            line_nxt = line_inc;
          end else if ((c == sts_pkg::CH_DQUOTE) || (c == sts_pkg::CH_SQUOTE)) begin
            va = 1'b1;
            res_a = sts_pkg::mk_res(qsingle_r ? sts_pkg::K_STRING : sts_pkg::K_IDENT, ts16,
                                    span_off1, line_r, '0, '0, sts_pkg::E_NONE);
            mode_nxt = M_IDLE;
          end
        end
        M_INT: begin
          if (is_dig) begin
            acc_nxt = dig_acc;
            ovf_nxt = dig_ovf;
          end else if (c == sts_pkg::CH_DOT) begin
            mode_nxt = M_FRAC;
          end else begin
            va = 1'b1;
            if (ovf_r) begin
              res_a = sts_pkg::mk_res(sts_pkg::K_ERROR, ts16, span_off, line_r, '0, '0,
                                      sts_pkg::E_RANGE);
              mode_nxt = M_HALT;
            end else begin
              res_a = sts_pkg::mk_res(sts_pkg::K_INT, ts16, span_off, line_r, sval, '0,
                                      sts_pkg::E_NONE);
              mode_nxt = M_IDLE;
              do_idle = 1'b1;
            end
          end
        end
        M_FRAC: begin
          if (is_dig) begin
            acc_nxt = dig_acc;
            ovf_nxt = dig_ovf;
            if (frac_r != sts_pkg::FRAC_MAX) begin
              frac_nxt = frac_r + 8'd1;
            end
          end else begin
            va = 1'b1;
            res_a = sts_pkg::mk_res(sts_pkg::K_DOUBLE, ts16, span_off, line_r, sval, frac_r,
                                    sts_pkg::E_NONE);
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        default: mode_nxt = M_HALT;
      endcase

      if (do_idle) begin
        tstart_nxt = off_r;
        unique case (c)
          sts_pkg::CH_SPACE, sts_pkg::CH_CR, sts_pkg::CH_TAB: begin
          end
          sts_pkg::CH_LF: line_nxt = line_inc;
          sts_pkg::CH_LPAREN: begin
            vb = 1'b1;
            res_b = sts_pkg::mk_res(sts_pkg::K_LPAREN, off16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end
          sts_pkg::CH_RPAREN: begin
            vb = 1'b1;
            res_b = sts_pkg::mk_res(sts_pkg::K_RPAREN, off16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end
          sts_pkg::CH_COMMA: begin
            vb = 1'b1;
            res_b = sts_pkg::mk_res(sts_pkg::K_COMMA, off16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end
          sts_pkg::CH_DOT: begin
            vb = 1'b1;
            res_b = sts_pkg::mk_res(sts_pkg::K_DOT, off16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end
          sts_pkg::CH_SEMI: begin
            vb = 1'b1;
            res_b = sts_pkg::mk_res(sts_pkg::K_SEMI, off16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end
          sts_pkg::CH_STAR: begin
            vb = 1'b1;
            res_b = sts_pkg::mk_res(sts_pkg::K_MUL, off16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end
          sts_pkg::CH_PCT: begin
            vb = 1'b1;
            res_b = sts_pkg::mk_res(sts_pkg::K_MOD, off16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end
          sts_pkg::CH_SLASH: begin
            vb = 1'b1;
            res_b = sts_pkg::mk_res(sts_pkg::K_DIV, off16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end
          sts_pkg::CH_EQ: begin
            vb = 1'b1;
            res_b = sts_pkg::mk_res(sts_pkg::K_EQ, off16, 16'd1, line_r, '0, '0,
                                    sts_pkg::E_NONE);
          end
          sts_pkg::CH_MINUS: mode_nxt = M_MINUS;
          sts_pkg::CH_PLUS: mode_nxt = M_PLUS;
          sts_pkg::CH_LT: mode_nxt = M_LT;
          sts_pkg::CH_GT: mode_nxt = M_GT;
          sts_pkg::CH_DQUOTE: begin
            qsingle_nxt = 1'b0;
            mode_nxt = M_QUOTE;
          end
          sts_pkg::CH_SQUOTE: begin
            qsingle_nxt = 1'b1;
            mode_nxt = M_QUOTE;
          end
          default: begin
            if (is_dig) begin
              acc_nxt = dig_acc;
              neg_nxt = 1'b0;
              frac_nxt = '0;
              ovf_nxt = dig_ovf;
              mode_nxt = M_INT;
            end else begin
              vb = 1'b1;
              res_b = sts_pkg::mk_res(sts_pkg::K_ERROR, off16, 16'd1, line_r, '0, '0,
                                      sts_pkg::E_UNEXPECTED);
              mode_nxt = M_HALT;
            end
          end
        endcase
      end
    end
  end

  assign n_res = {1'b0, va} + {1'b0, vb};
  assign e0 = {(va ? res_a : res_b), (n_res == 2'd1)};
  assign e1 = {res_b, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      qsingle_r <= 1'b0;
      off_r <= '0;
      tstart_r <= '0;
      line_r <= 16'd1;
      acc_r <= '0;
      neg_r <= 1'b0;
      frac_r <= '0;
      ovf_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (accept) begin
        mode_r <= mode_nxt;
        qsingle_r <= qsingle_nxt;
        off_r <= off_nxt;
        tstart_r <= tstart_nxt;
        line_r <= line_nxt;
        acc_r <= acc_nxt;
        neg_r <= neg_nxt;
        frac_r <= frac_nxt;
        ovf_r <= ovf_nxt;
        wr_ptr_r <= wr_ptr_r + sts_pkg::OQ_AW'(n_res);
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (accept ? (sts_pkg::OQ_AW + 1)'(n_res) : '0)
                 - (sts_pkg::OQ_AW + 1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (n_res != 2'd0)) begin
      mem_r[wr_ptr_r] <= e0;
    end
    if (accept && (n_res == 2'd2)) begin
      mem_r[sts_pkg::OQ_AW'(wr_ptr_r + 1'b1)] <= e1;
    end
  end

  assign out_tvalid = (count_r != '0);
  assign out_tuser = mem_r[rd_ptr_r].res.kind;
  assign out_tlast = mem_r[rd_ptr_r].last;
  assign out_tdata = {6'd0,
                      mem_r[rd_ptr_r].res.error_cause,
                      mem_r[rd_ptr_r].res.fraction_digits,
                      mem_r[rd_ptr_r].res.number_value,
                      mem_r[rd_ptr_r].res.line_number,
                      mem_r[rd_ptr_r].res.lexeme_length,
                      mem_r[rd_ptr_r].res.start_offset};

endmodule
